/* sv/spd_pkg.sv */
// ----------------------------------------------------------------------------
// Serial packet deframer package
// Shared widths, codes, configuration and result types for the deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned IdW      = 16;
  localparam int unsigned LenW     = 8;
  localparam int unsigned AngleW   = 16;
  localparam int unsigned EventW   = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [2:0] {
    PhHunt    = 3'd0,
    PhIdLo    = 3'd1,
    PhIdHi    = 3'd2,
    PhLen     = 3'd3,
    PhPayload = 3'd4,
    PhCheck   = 3'd5
  } spd_phase_e;

  typedef enum logic [EventW-1:0] {
    EvData = 2'd0,
    EvGood = 2'd1,
    EvBad  = 2'd2
  } spd_event_e;

  localparam logic [CfgIdxW-1:0] CfgStartByte = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEncoderId = 2'd1;

  localparam logic [AngleW-1:0] InvalidAngle = 16'hFFFF;
  localparam logic [LenW-1:0]   AngleBytes   = 8'd4;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [IdW-1:0]   encoder_frame_id;
  } spd_cfg_t;

  typedef struct packed {
    spd_event_e        event_res;
    logic [IdW-1:0]    frame_id;
    logic [LenW-1:0]   byte_index;
    logic [ByteW-1:0]  data_byte;
    logic [LenW-1:0]   frame_length;
    logic              angles_present;
    logic [AngleW-1:0] first_angle;
    logic              first_invalid;
    logic [AngleW-1:0] second_angle;
    logic              second_invalid;
  } spd_result_t;

endpackage

/* sv/spd_rx_if.sv */
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one byte from the serial link per request.
// ----------------------------------------------------------------------------
interface spd_rx_if;
  logic                      valid;
  logic                      ready;
  logic [spd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* sv/spd_res_if.sv */
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel carrying one payload or end-of-frame result per request.
// ----------------------------------------------------------------------------
interface spd_res_if;
  logic                        valid;
  logic                        ready;
  logic [spd_pkg::EventW-1:0]  event_res;
  logic [spd_pkg::IdW-1:0]     frame_id;
  logic [spd_pkg::LenW-1:0]    byte_index;
  logic [spd_pkg::ByteW-1:0]   data_byte;
  logic [spd_pkg::LenW-1:0]    frame_length;
  logic                        angles_present;
  logic [spd_pkg::AngleW-1:0]  first_angle;
  logic                        first_invalid;
  logic [spd_pkg::AngleW-1:0]  second_angle;
  logic                        second_invalid;

  modport source (
    output valid, output event_res, output frame_id, output byte_index,
    output data_byte, output frame_length, output angles_present,
    output first_angle, output first_invalid, output second_angle,
    output second_invalid, input ready
  );
  modport sink (
    input valid, input event_res, input frame_id, input byte_index,
    input data_byte, input frame_length, input angles_present,
    input first_angle, input first_invalid, input second_angle,
    input second_invalid, output ready
  );
endinterface

/* sv/spd_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data per request.
// ----------------------------------------------------------------------------
interface spd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [spd_pkg::CfgIdxW-1:0]  index;
  logic [spd_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/serial_packet_deframer_top.sv */
// ----------------------------------------------------------------------------
// Serial packet deframer
// Recovers start/id/length/payload/XOR-checksum frames from a byte stream.
//
//   Channel  Dir  Carries
//   rx_i     in   one received byte per request
//   res_o    out  payload byte or end-of-frame result per request
//   cfg_i    in   register index and write data per request
//
// One byte is accepted every cycle while the result register has room; a byte
// waits in the input register and its result is registered for res_o.
// The frame logic updates its state in a single pass per byte.
// A result register with one skid entry lets input continue while a result
// waits; input stalls only once both output entries are held.
// Reset returns the deframer to hunting with both registers cleared.
// ----------------------------------------------------------------------------
module serial_packet_deframer_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  spd_rx_if.sink    rx_i,
  spd_res_if.source res_o,
  spd_cfg_if.sink   cfg_i
);

  spd_pkg::spd_cfg_t         cfg_q, cfg_d;
  spd_pkg::spd_result_t      core_res;
  logic                      core_res_valid;
  logic                      byte_valid;
  logic [spd_pkg::ByteW-1:0] byte_val;
  logic                      res_space;
  logic                      take;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        spd_pkg::CfgStartByte: cfg_d.start_byte = cfg_i.data[spd_pkg::ByteW-1:0];
        spd_pkg::CfgEncoderId: cfg_d.encoder_frame_id = cfg_i.data[spd_pkg::IdW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign take = byte_valid && res_space;

  spd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .take_i       (take),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_val)
  );

  spd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .take_i      (take),
    .byte_i      (byte_val),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  spd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (core_res_valid),
    .data_i  (core_res),
    .space_o (res_space),
    .res_o   (res_o)
  );

`ifndef SYNTH
  a_push_has_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_res_valid |-> res_space)
    else $error("result produced with no room in the result register");

  a_event_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.event_res == spd_pkg::EvData ||
                     res_o.event_res == spd_pkg::EvGood ||
                     res_o.event_res == spd_pkg::EvBad))
    else $error("illegal event code on result channel");

  a_data_no_angles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.event_res == spd_pkg::EvData) |->
      (!res_o.angles_present && !res_o.first_invalid && !res_o.second_invalid))
    else $error("payload result carries angle information");

  a_angles_good_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.angles_present) |-> (res_o.event_res == spd_pkg::EvGood &&
      res_o.frame_length >= spd_pkg::AngleBytes))
    else $error("angles reported for a frame that is not a good encoder frame");
`endif

endmodule

/* sv/spd_in_reg.sv */
// ----------------------------------------------------------------------------
// Deframer input register
// Holds one received byte until the frame logic takes it.
// ----------------------------------------------------------------------------
module spd_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  spd_rx_if.sink                    rx_i,
  input  logic                      take_i,
  output logic                      byte_valid_o,
  output logic [spd_pkg::ByteW-1:0] byte_o
);

  logic                      valid_q, valid_d;
  logic [spd_pkg::ByteW-1:0] byte_q, byte_d;
  logic                      accept;

  // The register may be refilled in the same cycle its byte is taken.
  assign rx_i.ready = !valid_q || take_i;
  assign accept     = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (accept) begin
      valid_d = 1'b1;
      byte_d  = rx_i.rx_byte;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

/* sv/spd_core.sv */
// ----------------------------------------------------------------------------
// Deframer frame logic
// Phase tracking, header capture, running checksum and result formation.
// ----------------------------------------------------------------------------
module spd_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spd_pkg::spd_cfg_t         cfg_i,
  input  logic                      take_i,
  input  logic [spd_pkg::ByteW-1:0] byte_i,
  output logic                      res_valid_o,
  output spd_pkg::spd_result_t      res_o
);

  spd_pkg::spd_phase_e        phase_q, phase_d;
  logic [spd_pkg::IdW-1:0]    id_q, id_d;
  logic [spd_pkg::LenW-1:0]   len_q, len_d;
  logic [spd_pkg::LenW-1:0]   seen_q, seen_d;
  logic [spd_pkg::ByteW-1:0]  xor_q, xor_d;
  logic [spd_pkg::AngleW-1:0] ang0_q, ang0_d;
  logic [spd_pkg::AngleW-1:0] ang1_q, ang1_d;
  logic [spd_pkg::LenW-1:0]   seen_inc;
  logic                       good;
  logic                       angles_ok;

  assign seen_inc  = seen_q + 1'b1;
  assign good      = (byte_i == xor_q);
  assign angles_ok = good && (id_q == cfg_i.encoder_frame_id) &&
                     (len_q >= spd_pkg::AngleBytes);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (take_i) begin
      unique case (phase_q)
        spd_pkg::PhHunt: begin
          if (byte_i == cfg_i.start_byte) phase_d = spd_pkg::PhIdLo;
        end
        spd_pkg::PhIdLo: phase_d = spd_pkg::PhIdHi;
        spd_pkg::PhIdHi: phase_d = spd_pkg::PhLen;
        spd_pkg::PhLen: begin
          phase_d = (byte_i == '0) ? spd_pkg::PhCheck : spd_pkg::PhPayload;
        end
        spd_pkg::PhPayload: begin
          if (seen_inc == len_q) phase_d = spd_pkg::PhCheck;
        end
        spd_pkg::PhCheck: phase_d = spd_pkg::PhHunt;
        default: phase_d = spd_pkg::PhHunt;
      endcase
    end
  end

  // Frame fields and results.
  always_comb begin
    id_d        = id_q;
    len_d       = len_q;
    seen_d      = seen_q;
    xor_d       = xor_q;
    ang0_d      = ang0_q;
    ang1_d      = ang1_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.frame_id     = id_q;
    res_o.frame_length = len_q;
    if (take_i) begin
      unique case (phase_q)
        spd_pkg::PhHunt: begin
          if (byte_i == cfg_i.start_byte) begin
            id_d   = '0;
            len_d  = '0;
            seen_d = '0;
            xor_d  = '0;
            ang0_d = '0;
            ang1_d = '0;
          end
        end
        spd_pkg::PhIdLo: begin
          id_d  = {{(spd_pkg::IdW-spd_pkg::ByteW){1'b0}}, byte_i};
          xor_d = byte_i;
        end
        spd_pkg::PhIdHi: begin
          id_d  = {byte_i, id_q[spd_pkg::ByteW-1:0]};
          xor_d = xor_q ^ byte_i;
        end
        spd_pkg::PhLen: begin
          len_d  = byte_i;
          xor_d  = xor_q ^ byte_i;
          seen_d = '0;
        end
        spd_pkg::PhPayload: begin
          xor_d  = xor_q ^ byte_i;
          seen_d = seen_inc;
          // The first four payload bytes hold the two little-endian angles.
          if (seen_q < spd_pkg::AngleBytes) begin
            unique case (seen_q[1:0])
              2'd0: ang0_d = {ang0_q[spd_pkg::AngleW-1:spd_pkg::ByteW], byte_i};
              2'd1: ang0_d = {byte_i, ang0_q[spd_pkg::ByteW-1:0]};
              2'd2: ang1_d = {ang1_q[spd_pkg::AngleW-1:spd_pkg::ByteW], byte_i};
              default: ang1_d = {byte_i, ang1_q[spd_pkg::ByteW-1:0]};
            endcase
          end
          res_valid_o      = 1'b1;
          res_o.event_res  = spd_pkg::EvData;
          res_o.byte_index = seen_q;
          res_o.data_byte  = byte_i;
        end
        spd_pkg::PhCheck: begin
          res_valid_o     = 1'b1;
          res_o.event_res = good ? spd_pkg::EvGood : spd_pkg::EvBad;
          if (angles_ok) begin
            res_o.angles_present = 1'b1;
            res_o.first_angle    = ang0_q;
            res_o.first_invalid  = (ang0_q == spd_pkg::InvalidAngle);
            res_o.second_angle   = ang1_q;
            res_o.second_invalid = (ang1_q == spd_pkg::InvalidAngle);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= spd_pkg::PhHunt;
      id_q    <= '0;
      len_q   <= '0;
      seen_q  <= '0;
      xor_q   <= '0;
      ang0_q  <= '0;
      ang1_q  <= '0;
    end else begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      xor_q   <= xor_d;
      ang0_q  <= ang0_d;
      ang1_q  <= ang1_d;
    end
  end

endmodule

/* sv/spd_out_reg.sv */
// ----------------------------------------------------------------------------
// Deframer result register
// Output register with one skid entry; the input stalls only while the skid entry is full.
// ----------------------------------------------------------------------------
module spd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  spd_pkg::spd_result_t data_i,
  output logic                 space_o,
  spd_res_if.source            res_o
);

  logic                 out_valid_q, out_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  spd_pkg::spd_result_t out_q, out_d;
  spd_pkg::spd_result_t skid_q, skid_d;
  logic                 pop;

  assign pop     = out_valid_q && res_o.ready;
  assign space_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.event_res      = out_q.event_res;
  assign res_o.frame_id       = out_q.frame_id;
  assign res_o.byte_index     = out_q.byte_index;
  assign res_o.data_byte      = out_q.data_byte;
  assign res_o.frame_length   = out_q.frame_length;
  assign res_o.angles_present = out_q.angles_present;
  assign res_o.first_angle    = out_q.first_angle;
  assign res_o.first_invalid  = out_q.first_invalid;
  assign res_o.second_angle   = out_q.second_angle;
  assign res_o.second_invalid = out_q.second_invalid;

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Serial packet deframer testbench
// Drives received bytes through the deframer with bursty input and a
// stalling result consumer. A scoreboard class tracks the frame state, the
// start byte and the encoder id, predicts each payload and end-of-frame result
// and checks every result field against it. A short hand-built run is
// followed by four phases of random frames under different register settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ByteTarget   = 1350;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxPrinted   = 40;

  // Indexes that decode to no register; writes to them must change nothing.
  localparam logic [spd_pkg::CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [spd_pkg::CfgIdxW-1:0] CfgSpareHi = 2'd3;

  typedef enum logic [1:0] {
    RdyAlways,
    RdyCoin,
    RdyQuarter,
    RdyMostly
  } ready_mode_e;

  typedef logic [spd_pkg::ByteW-1:0] byte_q_t[$];

  class deframe_scoreboard;
    logic [spd_pkg::ByteW-1:0]  start_byte;
    logic [spd_pkg::IdW-1:0]    encoder_id;
    spd_pkg::spd_phase_e        phase;
    logic [spd_pkg::IdW-1:0]    id_acc;
    logic [spd_pkg::LenW-1:0]   length;
    logic [spd_pkg::LenW-1:0]   seen;
    logic [spd_pkg::ByteW-1:0]  xor_acc;
    logic [spd_pkg::AngleW-1:0] angle [2];
    spd_pkg::spd_result_t       expected_q[$];
    int unsigned                errors;

    function new();
      start_byte = '0;
      encoder_id = '0;
      phase      = spd_pkg::PhHunt;
      id_acc     = '0;
      length     = '0;
      seen       = '0;
      xor_acc    = '0;
      angle[0]   = '0;
      angle[1]   = '0;
      errors     = 0;
    endfunction

    function void write_register(logic [spd_pkg::CfgIdxW-1:0] idx,
                                 logic [spd_pkg::CfgDataW-1:0] data);
      case (idx)
        spd_pkg::CfgStartByte: start_byte = data[spd_pkg::ByteW-1:0];
        spd_pkg::CfgEncoderId: encoder_id = data[spd_pkg::IdW-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [spd_pkg::ByteW-1:0] b);
      spd_pkg::spd_result_t r;
      r = '0;
      case (phase)
        spd_pkg::PhIdLo: begin
          id_acc  = spd_pkg::IdW'(b);
          xor_acc = b;
          phase   = spd_pkg::PhIdHi;
        end
        spd_pkg::PhIdHi: begin
          id_acc[spd_pkg::IdW-1:spd_pkg::ByteW] = b;
          xor_acc ^= b;
          phase = spd_pkg::PhLen;
        end
        spd_pkg::PhLen: begin
          length = b;
          xor_acc ^= b;
          seen = '0;
          phase = (b == '0) ? spd_pkg::PhCheck : spd_pkg::PhPayload;
        end
        spd_pkg::PhPayload: begin
          xor_acc ^= b;
          // The first four payload bytes build two little-endian angles.
          if (seen < spd_pkg::AngleBytes) begin
            if (seen[0]) angle[seen[1]][15:8] = b;
            else         angle[seen[1]][7:0]  = b;
          end
          r.event_res    = spd_pkg::EvData;
          r.frame_id     = id_acc;
          r.byte_index   = seen;
          r.data_byte    = b;
          r.frame_length = length;
          expected_q.insert(expected_q.size(), r);
          seen++;
          if (seen == length) phase = spd_pkg::PhCheck;
        end
        spd_pkg::PhCheck: begin
          r.event_res    = (b == xor_acc) ? spd_pkg::EvGood : spd_pkg::EvBad;
          r.frame_id     = id_acc;
          r.frame_length = length;
          if (b == xor_acc && id_acc == encoder_id && length >= spd_pkg::AngleBytes) begin
            r.angles_present = 1'b1;
            r.first_angle    = angle[0];
            r.first_invalid  = (angle[0] == spd_pkg::InvalidAngle);
            r.second_angle   = angle[1];
            r.second_invalid = (angle[1] == spd_pkg::InvalidAngle);
          end
          expected_q.insert(expected_q.size(), r);
          phase = spd_pkg::PhHunt;
        end
        default: begin
          if (b == start_byte) begin
            phase    = spd_pkg::PhIdLo;
            id_acc   = '0;
            xor_acc  = '0;
            seen     = '0;
            length   = '0;
            angle[0] = '0;
            angle[1] = '0;
          end
        end
      endcase
    endfunction

    task report_mismatch(string what);
      if (errors < MaxPrinted) $display("mismatch: %s", what);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
      end
    endtask

    task check_result(spd_pkg::spd_result_t got);
      spd_pkg::spd_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result arrived with nothing outstanding");
        return;
      end
      want = expected_q.pop_front();
      compare_field("event_res", 16'(got.event_res), 16'(want.event_res));
      compare_field("frame_id", got.frame_id, want.frame_id);
      compare_field("byte_index", 16'(got.byte_index), 16'(want.byte_index));
      compare_field("data_byte", 16'(got.data_byte), 16'(want.data_byte));
      compare_field("frame_length", 16'(got.frame_length), 16'(want.frame_length));
      compare_field("angles_present", 16'(got.angles_present), 16'(want.angles_present));
      compare_field("first_angle", got.first_angle, want.first_angle);
      compare_field("first_invalid", 16'(got.first_invalid), 16'(want.first_invalid));
      compare_field("second_angle", got.second_angle, want.second_angle);
      compare_field("second_invalid", 16'(got.second_invalid), 16'(want.second_invalid));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  spd_rx_if  rx_if ();
  spd_res_if res_if ();
  spd_cfg_if cfg_if ();

  serial_packet_deframer_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  deframe_scoreboard sb;
  byte_q_t           frame_bytes;
  byte_q_t           payload_bytes;
  int unsigned       bytes_sent;
  int unsigned       burst_left;
  int unsigned       cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result consumer: switches between randomly chosen stall patterns.
  initial begin : ready_pattern
    ready_mode_e mode;
    int unsigned left;
    mode = RdyAlways;
    left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = ready_mode_e'($urandom_range(0, 3));
        left = $urandom_range(8, 80);
      end
      left--;
      case (mode)
        RdyAlways:  res_if.ready <= 1'b1;
        RdyCoin:    res_if.ready <= 1'($urandom_range(0, 1));
        RdyQuarter: res_if.ready <= (left % 4 == 0);
        default:    res_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : result_monitor
    spd_pkg::spd_result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.event_res      = spd_pkg::spd_event_e'(res_if.event_res);
      got.frame_id       = res_if.frame_id;
      got.byte_index     = res_if.byte_index;
      got.data_byte      = res_if.data_byte;
      got.frame_length   = res_if.frame_length;
      got.angles_present = res_if.angles_present;
      got.first_angle    = res_if.first_angle;
      got.first_invalid  = res_if.first_invalid;
      got.second_angle   = res_if.second_angle;
      got.second_invalid = res_if.second_invalid;
      sb.check_result(got);
    end
  end

  // Bytes go out in bursts; a gap of zero keeps valid high into the next burst.
  task automatic send_byte(logic [spd_pkg::ByteW-1:0] b, bit counted);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 5);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    sb.note_byte(b);
    burst_left--;
    if (counted) bytes_sent++;
  endtask

  task automatic send_span(int unsigned from, int unsigned upto);
    for (int unsigned i = from; i < upto; i++) send_byte(frame_bytes[i], 1'b1);
  endtask

  // Waits until every result is back, then lets the pipeline settle so that
  // bytes that cause no result have also been consumed.
  task automatic wait_quiet();
    rx_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Leaves valid high; the caller lowers it after the last request.
  task automatic write_reg(logic [spd_pkg::CfgIdxW-1:0] idx,
                           logic [spd_pkg::CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_register(idx, data);
  endtask

  task automatic configure(logic [spd_pkg::ByteW-1:0] start,
                           logic [spd_pkg::IdW-1:0] enc_id, bit spare);
    wait_quiet();
    write_reg(spd_pkg::CfgStartByte, {spd_pkg::ByteW'($urandom), start});
    write_reg(spd_pkg::CfgEncoderId, enc_id);
    if (spare) begin
      write_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi,
                spd_pkg::CfgDataW'($urandom));
    end
    cfg_if.valid <= 1'b0;
  endtask

  function automatic void fill_payload(int unsigned len, bit ones_first, bit ones_second);
    payload_bytes.delete();
    for (int unsigned i = 0; i < len; i++) begin
      payload_bytes.insert(payload_bytes.size(), spd_pkg::ByteW'($urandom));
    end
    if (ones_first && len >= 2) begin
      payload_bytes[0] = '1;
      payload_bytes[1] = '1;
    end
    if (ones_second && len >= 4) begin
      payload_bytes[2] = '1;
      payload_bytes[3] = '1;
    end
  endfunction

  function automatic void build_frame(logic [spd_pkg::IdW-1:0] id,
                                      logic [spd_pkg::ByteW-1:0] chk_flip);
    logic [spd_pkg::ByteW-1:0] chk;
    logic [spd_pkg::LenW-1:0]  len;
    len = spd_pkg::LenW'(payload_bytes.size());
    chk = id[7:0] ^ id[15:8] ^ len;
    frame_bytes.delete();
    frame_bytes.insert(frame_bytes.size(), sb.start_byte);
    frame_bytes.insert(frame_bytes.size(), id[7:0]);
    frame_bytes.insert(frame_bytes.size(), id[15:8]);
    frame_bytes.insert(frame_bytes.size(), len);
    foreach (payload_bytes[i]) begin
      chk ^= payload_bytes[i];
      frame_bytes.insert(frame_bytes.size(), payload_bytes[i]);
    end
    frame_bytes.insert(frame_bytes.size(), chk ^ chk_flip);
  endfunction

  // Mostly well-formed frames; the rest is line noise, corrupted checksums
  // and frames cut short so that later bytes land in the wrong field.
  task automatic random_segment();
    int unsigned               kind;
    int unsigned               pick;
    int unsigned               len;
    logic [spd_pkg::IdW-1:0]   id;
    logic [spd_pkg::ByteW-1:0] flip;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) send_byte(spd_pkg::ByteW'($urandom), 1'b0);
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 80)      len = $urandom_range(0, 8);
    else if (pick < 99) len = $urandom_range(9, 40);
    else                len = 255;
    id   = ($urandom_range(0, 9) < 3) ? sb.encoder_id : spd_pkg::IdW'($urandom);
    flip = ($urandom_range(0, 9) == 0) ? spd_pkg::ByteW'($urandom_range(1, 255)) : '0;
    fill_payload(len, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    build_frame(id, flip);
    if (kind < 90) send_span(0, frame_bytes.size());
    else           send_span(0, $urandom_range(1, frame_bytes.size() - 1));
  endtask

  initial begin
    sb = new();
    bytes_sent    = 0;
    burst_left    = 0;
    rst_ni        <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= '0;
    cfg_if.data   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hand-built frames: noise while hunting, an encoder frame whose id is
    // programmed half way through, an empty frame with a bad checksum that
    // carries the start byte in its id, and a short encoder frame.
    configure(8'hA5, 16'h0000, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    payload_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h00};
    build_frame(16'h1234, '0);
    send_span(0, 3);
    wait_quiet();
    write_reg(spd_pkg::CfgEncoderId, 16'h1234);
    cfg_if.valid <= 1'b0;
    send_span(3, frame_bytes.size());
    payload_bytes.delete();
    build_frame(16'hFFA5, 8'h80);
    send_span(0, frame_bytes.size());
    payload_bytes = '{8'hA5, 8'h00, 8'hFF};
    build_frame(16'h1234, '0);
    send_span(0, frame_bytes.size());

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       configure(8'h00, 16'h0000, 1'b0);
        1:       configure(8'hFF, 16'hFFFF, 1'b1);
        default: configure(spd_pkg::ByteW'($urandom), spd_pkg::IdW'($urandom), 1'b1);
      endcase
      if (p == 2) begin
        // One frame of the longest length to reach the last byte index.
        fill_payload(255, 1'b0, 1'b1);
        build_frame(sb.encoder_id, '0);
        send_span(0, frame_bytes.size());
      end
      while (bytes_sent < ByteTarget * (p + 1) / 4) random_segment();
    end

    wait_quiet();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
